FILE: rtl/mhss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mhss_pkg;

  // Hash constants
  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int          MIX_SHIFT   = 24;
  localparam int          FIN_SHIFT_A = 13;
  localparam int          FIN_SHIFT_B = 15;

  // Configuration
  localparam logic [31:0] SEED_RESET    = 32'd5381;
  localparam int          SRV_CNT_W     = 7;
  localparam int          MAX_SERVERS   = 64;
  localparam int          SRV_IDX_W     = 6;
  localparam int          CFG_IDX_W     = 1;
  localparam int          CFG_DATA_W    = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVERS = 1'b1;

  // Divider step count (one quotient bit per cycle)
  localparam int          DIV_STEPS = 32;
  localparam int          DIV_CNT_W = 5;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic [15:0] key_length;
    logic        first_item;
    logic        last_item;
  } in_item_t;

  typedef struct packed {
    logic [31:0]          hash_value;
    logic [SRV_IDX_W-1:0] server_index;
    logic                 protocol_error;
  } out_item_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD,
    OP_K1,
    OP_K2,
    OP_MH,
    OP_TAIL,
    OP_FIN,
    OP_DIV_STEP,
    OP_EMIT,
    OP_EMIT_ERR
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic short_word;
    logic full_word;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/mhss_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mhss_datapath import mhss_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire in_item_t              in_item_i,
  input  wire dp_cmd_t               cmd_i,
  output      dp_status_t            status_o,
  output      out_item_t             out_item_o
);

  // Configuration registers
  logic [31:0]          seed_q;
  logic [SRV_CNT_W-1:0] srv_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= SEED_RESET;
      srv_cnt_q <= SRV_CNT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SEED:    seed_q    <= cfg_data_i;
        CFG_SERVERS: srv_cnt_q <= cfg_data_i[SRV_CNT_W-1:0];
        default:     ;
      endcase
    end
  end

  // Captured item
  logic [31:0] word_q;
  logic [2:0]  cnt_q;
  logic [15:0] klen_q;
  logic        first_q, last_q;

  // Accumulator, mix temp, divider state, output payload
  logic [31:0]          h_q, h_d;
  logic [31:0]          t_q, t_d;
  logic [31:0]          hash_q, hash_d;
  logic [31:0]          dvd_q, dvd_d;
  logic [SRV_IDX_W-1:0] rem_q, rem_d;
  logic [DIV_CNT_W-1:0] dcnt_q, dcnt_d;
  out_item_t            out_q, out_d;

  // Clamp server count into 1..MAX_SERVERS
  logic [SRV_CNT_W-1:0] divisor;
  always_comb begin
    priority if (srv_cnt_q == '0) begin
      divisor = SRV_CNT_W'(1);
    end else if (srv_cnt_q > SRV_CNT_W'(MAX_SERVERS)) begin
      divisor = SRV_CNT_W'(MAX_SERVERS);
    end else begin
      divisor = srv_cnt_q;
    end
  end

  // Tail bytes kept by byte count
  logic [31:0] tail_mask;
  assign tail_mask = {8'h00,
                      {8{cnt_q >= 3'd3}},
                      {8{cnt_q >= 3'd2}},
                      {8{cnt_q >= 3'd1}}};

  // Shared constant multiplier
  logic [31:0] mul_a, mul_p, fin_x;
  logic [SRV_CNT_W-1:0] r_shift, r_sub;

  assign mul_p   = mul_a * MIX_MUL;
  assign fin_x   = mul_p ^ (mul_p >> FIN_SHIFT_B);
  assign r_shift = {rem_q, dvd_q[31]};
  assign r_sub   = r_shift - divisor;

  always_comb begin
    h_d    = h_q;
    t_d    = t_q;
    hash_d = hash_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dcnt_d = dcnt_q;
    out_d  = out_q;
    mul_a  = word_q;
    unique case (cmd_i.op)
      OP_LOAD: begin
        h_d = seed_q ^ {16'h0000, klen_q};
      end
      OP_K1: begin
        mul_a = word_q;
        t_d   = mul_p;
      end
      OP_K2: begin
        mul_a = t_q ^ (t_q >> MIX_SHIFT);
        t_d   = mul_p;
      end
      OP_MH: begin
        mul_a = h_q;
        h_d   = mul_p ^ t_q;
      end
      OP_TAIL: begin
        mul_a = h_q ^ (word_q & tail_mask);
        if (cnt_q != 3'd0) begin
          h_d = mul_p;
        end
      end
      OP_FIN: begin
        // avalanche, then load the divider
        mul_a  = h_q ^ (h_q >> FIN_SHIFT_A);
        hash_d = fin_x;
        dvd_d  = fin_x;
        rem_d  = '0;
        dcnt_d = '0;
      end
      OP_DIV_STEP: begin
        // restoring division, one quotient bit per cycle
        if (r_shift >= divisor) begin
          rem_d = r_sub[SRV_IDX_W-1:0];
        end else begin
          rem_d = r_shift[SRV_IDX_W-1:0];
        end
        dvd_d  = {dvd_q[30:0], 1'b0};
        dcnt_d = dcnt_q + DIV_CNT_W'(1);
      end
      OP_EMIT: begin
        out_d.hash_value     = hash_q;
        out_d.server_index   = rem_q;
        out_d.protocol_error = 1'b0;
      end
      OP_EMIT_ERR: begin
        out_d.hash_value     = '0;
        out_d.server_index   = '0;
        out_d.protocol_error = 1'b1;
      end
      default: ;
    endcase
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CAPTURE) begin
      word_q  <= in_item_i.data_word;
      cnt_q   <= (in_item_i.byte_count > 3'd4) ? 3'd4 : in_item_i.byte_count;
      klen_q  <= in_item_i.key_length;
      first_q <= in_item_i.first_item;
      last_q  <= in_item_i.last_item;
    end
    h_q    <= h_d;
    t_q    <= t_d;
    hash_q <= hash_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dcnt_q <= dcnt_d;
    out_q  <= out_d;
  end

  assign status_o.first      = first_q;
  assign status_o.last       = last_q;
  assign status_o.short_word = (cnt_q != 3'd4);
  assign status_o.full_word  = (cnt_q == 3'd4);
  assign status_o.div_done   = (dcnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign out_item_o          = out_q;

endmodule

`default_nettype wire

FILE: rtl/mhss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mhss_ctrl import mhss_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  input  wire dp_status_t status_i,
  output      dp_cmd_t    cmd_o
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DECODE   = 4'd1;
  localparam logic [3:0] ST_K1       = 4'd2;
  localparam logic [3:0] ST_K2       = 4'd3;
  localparam logic [3:0] ST_MH       = 4'd4;
  localparam logic [3:0] ST_TAIL     = 4'd5;
  localparam logic [3:0] ST_FIN      = 4'd6;
  localparam logic [3:0] ST_DIV      = 4'd7;
  localparam logic [3:0] ST_EMIT     = 4'd8;
  localparam logic [3:0] ST_EMIT_ERR = 4'd9;

  logic [3:0] state_q, state_d;
  logic       active_q, active_d;
  logic       ovalid_q, ovalid_d;
  logic       out_free;

  // output register can load when empty or being drained
  assign out_free = !ovalid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    active_d   = active_q;
    cmd_o.op   = OP_NONE;
    ovalid_d   = ovalid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.first) begin
          cmd_o.op = OP_LOAD;
        end
        if (!status_i.first && !active_q) begin
          // no key open: drop the item
          state_d = ST_IDLE;
        end else if (status_i.short_word && !status_i.last) begin
          active_d = 1'b0;
          state_d  = ST_EMIT_ERR;
        end else begin
          active_d = !status_i.last;
          state_d  = status_i.full_word ? ST_K1 : ST_TAIL;
        end
      end
      ST_K1: begin
        cmd_o.op = OP_K1;
        state_d  = ST_K2;
      end
      ST_K2: begin
        cmd_o.op = OP_K2;
        state_d  = ST_MH;
      end
      ST_MH: begin
        cmd_o.op = OP_MH;
        state_d  = status_i.last ? ST_FIN : ST_IDLE;
      end
      ST_TAIL: begin
        cmd_o.op = OP_TAIL;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.op = OP_FIN;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (status_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.op = OP_EMIT;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_EMIT_ERR: begin
        if (out_free) begin
          cmd_o.op = OP_EMIT_ERR;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      active_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = ovalid_q;

endmodule

`default_nettype wire

FILE: rtl/murmur2_key_hash_server_select_unit.sv
// A non-last full word passes through capture, decode and three multiply steps
// on the shared constant multiplier before the next item is accepted.
// A last word goes through mix or tail and avalanche, then through the
// one-bit-per-cycle remainder unit for server_index before its result.
// Reset (rst_ni, async low) closes any open key, empties the output register
// and restores seed 5381 and server count 1.
`timescale 1ns / 1ps
`default_nettype none

module murmur2_key_hash_server_select_unit import mhss_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire in_item_t              in_item_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      out_item_t             out_item_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  mhss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hash and remainder datapath
  mhss_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
